// File: rtl/stt_pkg.sv
// Shared constants, types and helper functions for the session time table.
`timescale 1ns / 1ps

package stt_pkg;

    // Table geometry.
    localparam int SLOTS = 16;
    localparam int IDX_W = $clog2(SLOTS);
    localparam int CNT_W = $clog2(SLOTS + 1);

    // Field widths of one transaction.
    localparam int OP_W      = 2;
    localparam int WEEK_W    = 6;
    localparam int WEEKDAY_W = 3;
    localparam int HOUR_W    = 5;
    localparam int MINUTE_W  = 6;
    localparam int KEY_W     = WEEK_W + WEEKDAY_W + HOUR_W + MINUTE_W;
    localparam int STATUS_W  = 2;
    localparam int OUT_CNT_W = 5;

    // Packed stream widths, rounded up to whole bytes.
    localparam int IN_BITS   = OP_W + KEY_W;
    localparam int IN_DATA_W = ((IN_BITS + 7) / 8) * 8;
    localparam int OUT_BITS  = STATUS_W + 2 * OUT_CNT_W;
    localparam int OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;

    // Day numbering starts at Monday.
    localparam logic [WEEKDAY_W-1:0] LUNDI = WEEKDAY_W'(1);

    // Operation codes.
    localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
    localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
    localparam logic [OP_W-1:0] OP_COUNT  = 2'd2;
    localparam logic [OP_W-1:0] OP_NONE   = 2'd3;

    // Status codes.
    localparam logic [STATUS_W-1:0] ST_DONE      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;

    // Largest count that fits the result fields.
    localparam logic [OUT_CNT_W-1:0] COUNT_MAX = '1;

    typedef logic [KEY_W-1:0] t_key;

    // Result of one key comparison from the shared compare unit.
    typedef struct packed {
        logic eq;   // stored key equals query key
        logic gt;   // stored key is strictly later than query key
    } t_cmp_res;

    // Saturate an internal count to the width of the result fields.
    function automatic logic [OUT_CNT_W-1:0] sat_cnt(input logic [CNT_W-1:0] n);
        logic [CNT_W+OUT_CNT_W-1:0] ext;
        ext = (CNT_W + OUT_CNT_W)'(n);
        if (ext > (CNT_W + OUT_CNT_W)'(COUNT_MAX)) begin
            return COUNT_MAX;
        end
        return ext[OUT_CNT_W-1:0];
    endfunction

endpackage

// File: rtl/session_time_table.sv
// Top level of the session time table: sequencer, valid bits and result register.
//
// Usage: each input transaction on the s_axis side carries one operation
// (insert, remove one equal key, or count stored keys strictly later than
// the key) together with a week/weekday/hour/minute key. Each one produces
// exactly one result transaction on the m_axis side with a status, the
// later-key count (count operation only) and the entry count afterward.
// Operation: the sequencer walks the slots in order through the key RAM,
// one slot per cycle behind a registered read. A count, a failed insert or
// a failed remove shows its result only after the scan has evaluated the
// last of the SLOTS slots; a successful insert or remove that uses slot k
// shows it as soon as the scan has evaluated slot k. The unused op code
// answers without a scan. One transaction is processed at a time: the
// input is ready again in the cycle after the result is taken.
// Reset clears all valid bits and the entry count at once; the table is
// empty and ready in the first cycle after reset. If the receiver stalls,
// the result is held on m_axis and no new input is accepted until it is
// taken.
`timescale 1ns / 1ps

module session_time_table (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // Input stream.
    input  logic                             i_s_axis_tvalid,
    output logic                             o_s_axis_tready,
    // tdata, low bit up: op[1:0], week[7:2], weekday[10:8], hour[15:11],
    // minute[21:16], zero fill[23:22].
    input  logic [stt_pkg::IN_DATA_W-1:0]    i_s_axis_tdata,
    // Result stream.
    output logic                             o_m_axis_tvalid,
    input  logic                             i_m_axis_tready,
    // tdata, low bit up: status[1:0], later_count[6:2], entry_count[11:7],
    // zero fill[15:12].
    output logic [stt_pkg::OUT_DATA_W-1:0]   o_m_axis_tdata
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_OUT  = 2'd2;

    localparam logic [stt_pkg::IDX_W-1:0] LAST_IDX = stt_pkg::IDX_W'(stt_pkg::SLOTS - 1);

    logic [1:0]                       r_state,      n_state;
    logic [stt_pkg::OP_W-1:0]         r_op,         n_op;
    stt_pkg::t_key                    r_key,        n_key;
    logic [stt_pkg::IDX_W-1:0]        r_idx,        n_idx;
    logic                             r_rd_more,    n_rd_more;
    logic                             r_cmp_vld,    n_cmp_vld;
    logic [stt_pkg::IDX_W-1:0]        r_cmp_idx,    n_cmp_idx;
    logic [stt_pkg::CNT_W-1:0]        r_later,      n_later;
    logic [stt_pkg::CNT_W-1:0]        r_entry,      n_entry;
    logic [stt_pkg::SLOTS-1:0]        r_valid,      n_valid;
    logic [stt_pkg::STATUS_W-1:0]     r_out_status, n_out_status;
    logic [stt_pkg::OUT_CNT_W-1:0]    r_out_later,  n_out_later;
    logic [stt_pkg::OUT_CNT_W-1:0]    r_out_entry,  n_out_entry;

    logic                             in_acc;
    logic [stt_pkg::OP_W-1:0]         in_op;
    stt_pkg::t_key                    in_key;
    logic                             ram_we;
    logic                             ram_re;
    stt_pkg::t_key                    ram_rdata;
    stt_pkg::t_cmp_res                cmp_res;
    logic                             slot_v;
    logic                             slot_last;
    logic [stt_pkg::CNT_W-1:0]        later_sum;

    // Unpack the input transaction.
    assign in_acc = i_s_axis_tvalid && o_s_axis_tready;
    assign in_op  = i_s_axis_tdata[1:0];
    assign in_key = {i_s_axis_tdata[7:2], i_s_axis_tdata[10:8],
                     i_s_axis_tdata[15:11], i_s_axis_tdata[21:16]};

    // Key storage, read one slot per cycle during the scan.
    assign ram_re = (r_state == S_SCAN) && r_rd_more;

    stt_ram #(
        .WIDTH (stt_pkg::KEY_W),
        .DEPTH (stt_pkg::SLOTS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_cmp_idx),
        .i_wdata (r_key),
        .i_re    (ram_re),
        .i_raddr (r_idx),
        .o_rdata (ram_rdata)
    );

    // Shared compare unit sees the slot whose key has just been read.
    stt_cmp u_cmp (
        .i_query  (r_key),
        .i_stored (ram_rdata),
        .o_res    (cmp_res)
    );

    assign slot_v    = r_valid[r_cmp_idx];
    assign slot_last = (r_cmp_idx == LAST_IDX);
    assign later_sum = r_later + stt_pkg::CNT_W'(slot_v && cmp_res.gt);

    // Sequencer: accept, scan the slots (skipped for the unused op code), then hold the result.
    always_comb begin
        n_state      = r_state;
        n_op         = r_op;
        n_key        = r_key;
        n_idx        = r_idx;
        n_rd_more    = r_rd_more;
        n_cmp_vld    = r_cmp_vld;
        n_cmp_idx    = r_cmp_idx;
        n_later      = r_later;
        n_entry      = r_entry;
        n_valid      = r_valid;
        n_out_status = r_out_status;
        n_out_later  = r_out_later;
        n_out_entry  = r_out_entry;
        ram_we       = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_op      = in_op;
                    n_key     = in_key;
                    n_idx     = '0;
                    n_rd_more = 1'b1;
                    n_cmp_vld = 1'b0;
                    n_later   = '0;
                    if (in_op == stt_pkg::OP_NONE) begin
                        n_out_status = stt_pkg::ST_DONE;
                        n_out_later  = '0;
                        n_out_entry  = stt_pkg::sat_cnt(r_entry);
                        n_state      = S_OUT;
                    end else begin
                        n_state = S_SCAN;
                    end
                end
            end

            S_SCAN: begin
                // Issue the next slot read.
                n_cmp_vld = r_rd_more;
                n_cmp_idx = r_idx;
                if (r_rd_more) begin
                    if (r_idx == LAST_IDX) begin
                        n_rd_more = 1'b0;
                    end else begin
                        n_idx = r_idx + 1'b1;
                    end
                end

                // Evaluate the slot read in the previous cycle.
                if (r_cmp_vld) begin
                    case (r_op)
                        stt_pkg::OP_INSERT: begin
                            if (!slot_v) begin
                                ram_we             = 1'b1;
                                n_valid[r_cmp_idx] = 1'b1;
                                n_entry            = r_entry + 1'b1;
                                n_out_status       = stt_pkg::ST_DONE;
                                n_out_later        = '0;
                                n_out_entry        = stt_pkg::sat_cnt(r_entry + 1'b1);
                                n_state            = S_OUT;
                            end else if (slot_last) begin
                                n_out_status = stt_pkg::ST_FULL;
                                n_out_later  = '0;
                                n_out_entry  = stt_pkg::sat_cnt(r_entry);
                                n_state      = S_OUT;
                            end
                        end
                        stt_pkg::OP_REMOVE: begin
                            if (slot_v && cmp_res.eq) begin
                                n_valid[r_cmp_idx] = 1'b0;
                                n_entry            = r_entry - 1'b1;
                                n_out_status       = stt_pkg::ST_DONE;
                                n_out_later        = '0;
                                n_out_entry        = stt_pkg::sat_cnt(r_entry - 1'b1);
                                n_state            = S_OUT;
                            end else if (slot_last) begin
                                n_out_status = stt_pkg::ST_NOT_FOUND;
                                n_out_later  = '0;
                                n_out_entry  = stt_pkg::sat_cnt(r_entry);
                                n_state      = S_OUT;
                            end
                        end
                        default: begin
                            // Count of stored keys strictly later than the query.
                            n_later = later_sum;
                            if (slot_last) begin
                                n_out_status = stt_pkg::ST_DONE;
                                n_out_later  = stt_pkg::sat_cnt(later_sum);
                                n_out_entry  = stt_pkg::sat_cnt(r_entry);
                                n_state      = S_OUT;
                            end
                        end
                    endcase
                end
            end

            S_OUT: begin
                if (i_m_axis_tready) begin
                    n_state = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control state with reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_entry <= '0;
            r_valid <= '0;
        end else begin
            r_state <= n_state;
            r_entry <= n_entry;
            r_valid <= n_valid;
        end
    end

    // Working and result registers.
    always_ff @(posedge i_clk) begin
        r_op         <= n_op;
        r_key        <= n_key;
        r_idx        <= n_idx;
        r_rd_more    <= n_rd_more;
        r_cmp_vld    <= n_cmp_vld;
        r_cmp_idx    <= n_cmp_idx;
        r_later      <= n_later;
        r_out_status <= n_out_status;
        r_out_later  <= n_out_later;
        r_out_entry  <= n_out_entry;
    end

    // Port outputs.
    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_m_axis_tvalid = (r_state == S_OUT);
    assign o_m_axis_tdata  = stt_pkg::OUT_DATA_W'({r_out_entry, r_out_later, r_out_status});

endmodule

// File: rtl/stt_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module stt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/stt_cmp.sv
// Shared key compare unit: one equality and one magnitude test per cycle.
`timescale 1ns / 1ps

module stt_cmp (
    input  stt_pkg::t_key     i_query,
    input  stt_pkg::t_key     i_stored,
    output stt_pkg::t_cmp_res o_res
);

    // The packed key puts week in the top bits, so an unsigned compare of
    // the whole word gives the lexicographic order of the four fields.
    always_comb begin
        o_res.eq = (i_stored == i_query);
        o_res.gt = (i_stored > i_query);
    end

endmodule

// File: rtl/stt_chk.sv
// Port-level assertions for the session time table, bound to the top level.
`timescale 1ns / 1ps

module stt_chk (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_s_axis_tvalid,
    input  logic                           o_s_axis_tready,
    input  logic [stt_pkg::IN_DATA_W-1:0]  i_s_axis_tdata,
    input  logic                           o_m_axis_tvalid,
    input  logic                           i_m_axis_tready,
    input  logic [stt_pkg::OUT_DATA_W-1:0] o_m_axis_tdata
);

    // One transaction at a time: no new input while a result is shown.
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_s_axis_tready && o_m_axis_tvalid))
        else $error("input ready while a result is pending");

    // After an input transaction the block is busy in the next cycle.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_axis_tvalid && o_s_axis_tready) |=> !o_s_axis_tready)
        else $error("input ready right after an accepted transaction");

    // A stalled result holds its value.
    a_hold_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !i_m_axis_tready) |=>
            (o_m_axis_tvalid && $stable(o_m_axis_tdata)))
        else $error("stalled result changed or dropped");

    // Status is a defined code and the entry count never exceeds the table.
    a_result_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |->
            ((o_m_axis_tdata[1:0] != 2'd3) &&
             (o_m_axis_tdata[11:7] <= stt_pkg::sat_cnt(stt_pkg::CNT_W'(stt_pkg::SLOTS)))))
        else $error("result carries an invalid status or entry count");

endmodule

bind session_time_table stt_chk u_stt_chk (.*);
